@@ rtl/core/usg_pkg.sv @@
package usg_pkg;

    // Quarter-wave sine table: entries 0..SINE_TABLE_ENTRIES, unsigned Q30.
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int WAVE_STEPS         = 4 * SINE_TABLE_ENTRIES;
    localparam int IDX_W              = $clog2(WAVE_STEPS) + 1;
    localparam int ROM_AW             = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int CNT_W              = 8;
    localparam int NUM_W              = IDX_W + CNT_W;

    localparam int UNIT_W   = 31;
    localparam int RADIUS_W = 24;
    localparam int COORD_W  = 25;
    localparam int PROD_W   = 2 * UNIT_W;

    localparam logic [UNIT_W-1:0]   UNIT_ONE  = UNIT_W'(1) << 30;
    localparam logic [RADIUS_W-1:0] COORD_MAX = '1;
    localparam longint unsigned     HALF_PI_Q30 = 64'd1686629713;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 80;

    localparam logic [2:0] LAST_CORNER = 3'd5;

    typedef logic [UNIT_W-1:0] t_sine_rom [0:SINE_TABLE_ENTRIES];

    typedef enum logic [1:0] {
        CFG_RADIUS  = 2'd0,
        CFG_COLUMNS = 2'd1,
        CFG_RINGS   = 2'd2
    } t_cfg_reg;

    // Division slots: theta index of the previous and current column, phi index
    // of the previous and current row.
    typedef enum logic [1:0] {
        DS_COL_PREV = 2'd0,
        DS_COL_CUR  = 2'd1,
        DS_ROW_PREV = 2'd2,
        DS_ROW_CUR  = 2'd3
    } t_div_slot;

    typedef enum logic [2:0] {
        MS_XW = 3'd0,
        MS_ZW = 3'd1,
        MS_XR = 3'd2,
        MS_ZR = 3'd3,
        MS_YR = 3'd4
    } t_mul_step;

    typedef struct packed {
        logic [RADIUS_W-1:0] radius;
        logic [CNT_W-1:0]    segs;
        logic [CNT_W-1:0]    rows;
    } t_geom;

    typedef struct packed {
        logic             div_start;
        t_div_slot        div_slot;
        logic             rom_rd;
        logic [2:0]       rom_sel;   // {row not column, current slot, cosine}
        logic             mul_en;
        t_mul_step        mul_step;
        logic [2:0]       corner;
        logic             load_out;
        logic [CNT_W-1:0] row;
        logic [CNT_W-1:0] col;
        logic             mesh_end;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_stat;

    // Divides by the Taylor denominator (2n)(2n+1) of term n.
    function automatic longint unsigned taylor_div(input longint unsigned v, input int n);
        longint unsigned q;
        unique case (n)
            1:       q = v / 64'd6;
            2:       q = v / 64'd20;
            3:       q = v / 64'd42;
            4:       q = v / 64'd72;
            5:       q = v / 64'd110;
            6:       q = v / 64'd156;
            7:       q = v / 64'd210;
            8:       q = v / 64'd272;
            9:       q = v / 64'd342;
            10:      q = v / 64'd420;
            11:      q = v / 64'd506;
            default: q = v / 64'd600;
        endcase
        return q;
    endfunction

    // Integer Taylor series of sin(pi/2 * k / N), evaluated at elaboration.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        int                k;
        int                n;
        for (k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
            x    = (HALF_PI_Q30 * longint'(k) + SINE_TABLE_ENTRIES / 2) / SINE_TABLE_ENTRIES;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 12; n++) begin
                term = (taylor_div(term * x2, n) + (64'd1 << 29)) >> 30;
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > longint'(UNIT_ONE) || k == SINE_TABLE_ENTRIES) begin
                sum = longint'(UNIT_ONE);
            end
            rom[k] = sum[UNIT_W-1:0];
        end
        return rom;
    endfunction

endpackage

@@ rtl/core/usg_divider.sv @@
module usg_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [usg_pkg::NUM_W-1:0] i_num,
    input  logic [usg_pkg::CNT_W-1:0] i_den,
    output logic                      o_done,
    output logic [usg_pkg::IDX_W-1:0] o_quot
);
    import usg_pkg::*;

    localparam int STEP_W = $clog2(IDX_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_den, n_den;
    logic [IDX_W-1:0]  r_low, n_low;
    logic [IDX_W-1:0]  r_quot, n_quot;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    // The quotient is known to fit IDX_W bits, so the upper numerator bits
    // seed the remainder and only IDX_W restoring steps remain.
    always_comb begin
        trial  = {r_rem, r_low[IDX_W-1]};
        fits   = trial >= {1'b0, r_den};
        diff   = trial - {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_low  = r_low;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = STEP_W'(IDX_W);
            n_rem  = i_num[NUM_W-1:IDX_W];
            n_low  = i_num[IDX_W-1:0];
            n_den  = i_den;
        end else if (r_busy) begin
            n_rem  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            n_quot = {r_quot[IDX_W-2:0], fits};
            n_low  = {r_low[IDX_W-2:0], 1'b0};
            n_cnt  = r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_low  <= n_low;
        r_quot <= n_quot;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ rtl/core/usg_datapath.sv @@
module usg_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  usg_pkg::t_geom                  i_geom,
    input  usg_pkg::t_cmd                   i_cmd,
    output usg_pkg::t_stat                  o_stat,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [usg_pkg::COORD_W-1:0]     o_x,
    output logic [usg_pkg::COORD_W-1:0]     o_y,
    output logic [usg_pkg::COORD_W-1:0]     o_z,
    output logic [2:0]                      o_corner,
    output logic                            o_last,
    output logic                            o_mesh_end
);
    import usg_pkg::*;

    localparam t_sine_rom SINE_ROM = build_sine_rom();
    localparam int N = SINE_TABLE_ENTRIES;

    // Corners 0..5 read rows (r-1, r-1, r, r-1, r, r) and
    // columns (c-1, c, c-1, c, c, c-1); slot 1 is the current row or column.
    function automatic logic row_cur(input logic [2:0] corner);
        logic v;
        unique case (corner)
            3'd2, 3'd4, 3'd5: v = 1'b1;
            default:          v = 1'b0;
        endcase
        return v;
    endfunction

    function automatic logic col_cur(input logic [2:0] corner);
        logic v;
        unique case (corner)
            3'd1, 3'd3, 3'd4: v = 1'b1;
            default:          v = 1'b0;
        endcase
        return v;
    endfunction

    // Division of angle indexes.
    logic             div_done;
    logic [IDX_W-1:0] div_quot;
    logic [NUM_W-1:0] div_num;
    logic [CNT_W-1:0] div_den;
    logic [CNT_W-1:0] col_prev, row_prev;
    t_div_slot        r_div_slot;
    logic [IDX_W-1:0] r_tidx [0:1];
    logic [IDX_W-1:0] r_pidx [0:1];

    assign col_prev = i_cmd.col - CNT_W'(1);
    assign row_prev = i_cmd.row - CNT_W'(1);

    always_comb begin
        unique case (i_cmd.div_slot)
            DS_COL_PREV: begin
                div_num = NUM_W'(col_prev) * NUM_W'(WAVE_STEPS) + NUM_W'(i_geom.segs >> 1);
                div_den = i_geom.segs;
            end
            DS_COL_CUR: begin
                div_num = NUM_W'(i_cmd.col) * NUM_W'(WAVE_STEPS) + NUM_W'(i_geom.segs >> 1);
                div_den = i_geom.segs;
            end
            DS_ROW_PREV: begin
                div_num = NUM_W'(row_prev) * NUM_W'(2 * N) + NUM_W'(i_geom.rows >> 1);
                div_den = i_geom.rows;
            end
            DS_ROW_CUR: begin
                div_num = NUM_W'(i_cmd.row) * NUM_W'(2 * N) + NUM_W'(i_geom.rows >> 1);
                div_den = i_geom.rows;
            end
            default: begin
                div_num = '0;
                div_den = i_geom.segs;
            end
        endcase
    end

    usg_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_slot <= i_cmd.div_slot;
        end
        if (div_done) begin
            unique case (r_div_slot)
                DS_COL_PREV: r_tidx[0] <= div_quot;
                DS_COL_CUR:  r_tidx[1] <= div_quot;
                DS_ROW_PREV: r_pidx[0] <= div_quot;
                DS_ROW_CUR:  r_pidx[1] <= div_quot;
                default:     r_tidx[0] <= div_quot;
            endcase
        end
    end

    // Sine table lookups: fold the wave index to a quarter and read the table.
    logic [IDX_W-1:0]  base_idx, wave_idx, fold_idx, quad_off;
    logic [1:0]        quad;
    logic [ROM_AW-1:0] rom_addr;
    logic              r_rd_vld;
    logic [2:0]        r_rd_sel;
    logic              r_rd_neg;
    logic [UNIT_W-1:0] r_rom_q;

    always_comb begin
        base_idx = i_cmd.rom_sel[2] ? r_pidx[i_cmd.rom_sel[1]] : r_tidx[i_cmd.rom_sel[1]];
        wave_idx = base_idx + (i_cmd.rom_sel[0] ? IDX_W'(N) : '0);
        fold_idx = (wave_idx >= IDX_W'(WAVE_STEPS)) ? wave_idx - IDX_W'(WAVE_STEPS)
                                                    : wave_idx;
        priority if (fold_idx >= IDX_W'(3 * N)) begin
            quad     = 2'd3;
            quad_off = fold_idx - IDX_W'(3 * N);
        end else if (fold_idx >= IDX_W'(2 * N)) begin
            quad     = 2'd2;
            quad_off = fold_idx - IDX_W'(2 * N);
        end else if (fold_idx >= IDX_W'(N)) begin
            quad     = 2'd1;
            quad_off = fold_idx - IDX_W'(N);
        end else begin
            quad     = 2'd0;
            quad_off = fold_idx;
        end
        rom_addr = quad[0] ? ROM_AW'(N) - quad_off[ROM_AW-1:0] : quad_off[ROM_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rom_rd;
        end
        if (i_cmd.rom_rd) begin
            r_rom_q  <= SINE_ROM[rom_addr];
            r_rd_sel <= i_cmd.rom_sel;
            r_rd_neg <= quad[1];
        end
    end

    // Capture with the seams applied: the last column has sin 0 and cos 1,
    // the last row has w 0 and y -1.
    logic [UNIT_W-1:0] cap_mag;
    logic              cap_neg;
    logic              seam;
    logic [UNIT_W-1:0] r_sx [0:1];
    logic [UNIT_W-1:0] r_cz [0:1];
    logic [UNIT_W-1:0] r_w  [0:1];
    logic [UNIT_W-1:0] r_y  [0:1];
    logic              r_sxn [0:1];
    logic              r_czn [0:1];
    logic              r_wn  [0:1];
    logic              r_yn  [0:1];

    always_comb begin
        seam = r_rd_sel[1] && (r_rd_sel[2] ? (i_cmd.row >= i_geom.rows)
                                           : (i_cmd.col >= i_geom.segs));
        if (seam) begin
            cap_mag = r_rd_sel[0] ? UNIT_ONE : '0;
            cap_neg = r_rd_sel[2] && r_rd_sel[0];
        end else begin
            cap_mag = r_rom_q;
            cap_neg = r_rd_neg && (r_rom_q != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            unique case ({r_rd_sel[2], r_rd_sel[0]})
                2'b00: begin
                    r_sx[r_rd_sel[1]]  <= cap_mag;
                    r_sxn[r_rd_sel[1]] <= cap_neg;
                end
                2'b01: begin
                    r_cz[r_rd_sel[1]]  <= cap_mag;
                    r_czn[r_rd_sel[1]] <= cap_neg;
                end
                2'b10: begin
                    r_w[r_rd_sel[1]]  <= cap_mag;
                    r_wn[r_rd_sel[1]] <= cap_neg;
                end
                default: begin
                    r_y[r_rd_sel[1]]  <= cap_mag;
                    r_yn[r_rd_sel[1]] <= cap_neg;
                end
            endcase
        end
    end

    // One shared multiplier, five products per vertex.
    logic              rs, cs;
    logic [UNIT_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] prod, prod_rnd;
    logic [31:0]       rnd;
    logic [RADIUS_W-1:0] sat;
    logic              coord_neg;
    logic [COORD_W-1:0]  coord;
    logic [UNIT_W-1:0] r_xm, r_zm;
    logic [COORD_W-1:0] r_cx, r_cy, r_cz_out;

    assign rs = row_cur(i_cmd.corner);
    assign cs = col_cur(i_cmd.corner);

    always_comb begin
        mul_b     = UNIT_W'(i_geom.radius);
        coord_neg = 1'b0;
        unique case (i_cmd.mul_step)
            MS_XW: begin
                mul_a = r_sx[cs];
                mul_b = r_w[rs];
            end
            MS_ZW: begin
                mul_a = r_cz[cs];
                mul_b = r_w[rs];
            end
            MS_XR: begin
                mul_a     = r_xm;
                coord_neg = (r_sxn[cs] != r_wn[rs]) && (r_xm != '0);
            end
            MS_ZR: begin
                mul_a     = r_zm;
                coord_neg = (r_czn[cs] != r_wn[rs]) && (r_zm != '0);
            end
            MS_YR: begin
                mul_a     = r_y[rs];
                coord_neg = r_yn[rs];
            end
            default: begin
                mul_a = '0;
            end
        endcase
        prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
        prod_rnd = prod + (PROD_W'(1) << 29);
        rnd      = prod_rnd[PROD_W-1:30];
        sat      = (rnd > 32'(COORD_MAX)) ? COORD_MAX : rnd[RADIUS_W-1:0];
        coord    = coord_neg ? COORD_W'(0) - {1'b0, sat} : {1'b0, sat};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            unique case (i_cmd.mul_step)
                MS_XW:   r_xm     <= rnd[UNIT_W-1:0];
                MS_ZW:   r_zm     <= rnd[UNIT_W-1:0];
                MS_XR:   r_cx     <= coord;
                MS_ZR:   r_cz_out <= coord;
                MS_YR:   r_cy     <= coord;
                default: r_cy     <= coord;
            endcase
        end
    end

    // Output register.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_out) begin
            o_x        <= r_cx;
            o_y        <= r_cy;
            o_z        <= r_cz_out;
            o_corner   <= i_cmd.corner;
            o_last     <= (i_cmd.corner == LAST_CORNER);
            o_mesh_end <= i_cmd.mesh_end;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = !r_out_valid || i_ready;

endmodule

@@ rtl/core/usg_ctrl.sv @@
module usg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  usg_pkg::t_geom i_geom,
    input  logic           i_valid,
    input  logic           i_restart,
    output logic           o_ready,
    input  usg_pkg::t_stat i_stat,
    output usg_pkg::t_cmd  o_cmd
);
    import usg_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_ROM  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_EMIT = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_row, n_row;
    logic [CNT_W-1:0] r_col, n_col;
    logic             r_fin, n_fin;
    logic             r_end, n_end;
    logic [3:0]       r_step, n_step;
    logic [2:0]       r_corner, n_corner;
    logic             r_div_run, n_div_run;
    logic [CNT_W:0]   adv_row;
    logic [CNT_W-1:0] adv_col;

    always_comb begin
        if (r_col >= i_geom.segs) begin
            adv_row = {1'b0, r_row} + (CNT_W+1)'(1);
            adv_col = CNT_W'(1);
        end else begin
            adv_row = {1'b0, r_row};
            adv_col = r_col + CNT_W'(1);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_col     = r_col;
        n_fin     = r_fin;
        n_end     = r_end;
        n_step    = r_step;
        n_corner  = r_corner;
        n_div_run = r_div_run;
        o_cmd          = '0;
        o_cmd.row      = r_row;
        o_cmd.col      = r_col;
        o_cmd.mesh_end = r_end;
        o_cmd.corner   = r_corner;
        o_cmd.div_slot = t_div_slot'(r_step[1:0]);
        o_cmd.rom_sel  = r_step[2:0];
        o_cmd.mul_step = t_mul_step'(r_step[2:0]);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    priority if (i_restart) begin
                        n_row   = CNT_W'(1);
                        n_col   = CNT_W'(1);
                        n_end   = (CNT_W'(1) >= i_geom.rows) && (CNT_W'(1) >= i_geom.segs);
                        n_fin   = n_end;
                        n_step  = '0;
                        n_state = ST_DIV;
                    end else if (r_fin) begin
                        n_fin = 1'b1;
                    end else if (adv_row > {1'b0, i_geom.rows}) begin
                        n_fin = 1'b1;
                    end else begin
                        n_row   = adv_row[CNT_W-1:0];
                        n_col   = adv_col;
                        n_end   = (adv_row[CNT_W-1:0] >= i_geom.rows) &&
                                  (adv_col >= i_geom.segs);
                        n_fin   = n_end;
                        n_step  = '0;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (!r_div_run) begin
                    o_cmd.div_start = 1'b1;
                    n_div_run       = 1'b1;
                end else if (i_stat.div_done) begin
                    n_div_run = 1'b0;
                    if (r_step == 4'd3) begin
                        n_step  = '0;
                        n_state = ST_ROM;
                    end else begin
                        n_step = r_step + 4'd1;
                    end
                end
            end
            ST_ROM: begin
                // Table data is registered behind the address, so the last
                // lookup is captured during the extra step.
                o_cmd.rom_rd = !r_step[3];
                if (r_step[3]) begin
                    n_step   = '0;
                    n_corner = '0;
                    n_state  = ST_MUL;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (t_mul_step'(r_step[2:0]) == MS_YR) begin
                    n_state = ST_EMIT;
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_step         = '0;
                    if (r_corner == LAST_CORNER) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_corner = r_corner + 3'd1;
                        n_state  = ST_MUL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row     <= CNT_W'(1);
            r_col     <= CNT_W'(1);
            r_fin     <= 1'b1;
            r_end     <= 1'b0;
            r_step    <= '0;
            r_corner  <= '0;
            r_div_run <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_fin     <= n_fin;
            r_end     <= n_end;
            r_step    <= n_step;
            r_corner  <= n_corner;
            r_div_run <= n_div_run;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule

@@ rtl/core/uv_sphere_triangle_generator.sv @@
// Channel      Direction  Payload
// s_axis       in         tdata[0] restart
// m_axis       out        tdata x, y, z, corner; tlast last; tuser mesh_end
// cfg          in         index 0 radius, 1 column count, 2 ring count
//
// A quad is built in steps: four angle divisions on the shared restoring
// divider, sine table lookups, then six vertices of five products each on
// the single shared multiplier, each vertex followed by a load into the
// output register.
// Reset is synchronous and active low; the block then waits for a restart.
// A stalled output holds the next vertex in the multiplier stage; a new
// transaction is taken while the sixth vertex still waits on m_axis.
module uv_sphere_triangle_generator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [usg_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [0] restart
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [24:0] vertex_x, [49:25] vertex_y, [74:50] vertex_z, [77:75] corner
    output logic [usg_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    output logic                               m_axis_tuser,   // [0] mesh_end
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [usg_pkg::RADIUS_W-1:0]       i_cfg_data
);
    import usg_pkg::*;

    logic [RADIUS_W-1:0] r_radius;
    logic [CNT_W-1:0]    r_columns;
    logic [CNT_W-1:0]    r_rings;
    t_geom               geom;
    t_cmd                cmd;
    t_stat               stat;
    logic [COORD_W-1:0]  vx, vy, vz;
    logic [2:0]          corner;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RADIUS_W'(32768);
            r_columns <= CNT_W'(32);
            r_rings   <= CNT_W'(16);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_RADIUS:  r_radius  <= i_cfg_data;
                CFG_COLUMNS: r_columns <= i_cfg_data[CNT_W-1:0];
                CFG_RINGS:   r_rings   <= i_cfg_data[CNT_W-1:0];
                default:     r_radius  <= r_radius;
            endcase
        end
    end

    // Zero columns acts as one; 255 rings acts as 254.
    always_comb begin
        geom.radius = r_radius;
        geom.segs   = (r_columns == '0) ? CNT_W'(1) : r_columns;
        geom.rows   = ((r_rings == '1) ? CNT_W'(254) : r_rings) + CNT_W'(1);
    end

    assign o_cfg_ready = 1'b1;

    usg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (geom),
        .i_valid   (s_axis_tvalid),
        .i_restart (s_axis_tdata[0]),
        .o_ready   (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    usg_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_x        (vx),
        .o_y        (vy),
        .o_z        (vz),
        .o_corner   (corner),
        .o_last     (m_axis_tlast),
        .o_mesh_end (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, corner, vz, vy, vx};

endmodule

@@ rtl/core/usg_checker.sv @@
module usg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("stalled vertex changed");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[77:75] == 3'd5)))
        else $error("tlast does not match the sixth corner");

    a_corner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[77:75] <= 3'd5))
        else $error("corner out of range");

    // Mid-quad the sequencer is busy with the remaining corners.
    a_busy_mid_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[77:75] != 3'd5) |-> !s_axis_tready)
        else $error("input taken before the quad was complete");

endmodule

bind uv_sphere_triangle_generator usg_checker u_usg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

@@ test/uv_sphere_triangle_generator_tb.sv @@
`timescale 1ns / 100ps

module uv_sphere_triangle_generator_tb;
    import usg_pkg::*;

    localparam int TABLE_N     = 1024;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 250;

    typedef struct {
        logic [24:0] x;
        logic [24:0] y;
        logic [24:0] z;
        logic [2:0]  corner;
        logic        last;
        logic        mesh_end;
    } t_vertex;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index;
    logic [RADIUS_W-1:0]    i_cfg_data;

    uv_sphere_triangle_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Sphere geometry and walk position as the block should hold them.
    longint unsigned sine_q30 [0:TABLE_N];
    int unsigned     geo_radius;
    int unsigned     geo_cols;
    int unsigned     geo_rings;
    int unsigned     walk_row;
    int unsigned     walk_col;
    bit              walk_done;

    t_vertex     vertex_q[$];
    int          error_count;
    int          vertex_count;
    int          quad_count;
    int          item_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic void build_sine_q30();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        for (int k = 0; k <= TABLE_N; k++) begin
            x    = (64'd1686629713 * k + TABLE_N / 2) / TABLE_N;
            x2   = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) / ((2 * n) * (2 * n + 1)) + (64'd1 << 29)) >> 30;
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) acc = 0;
            if (acc > (64'd1 << 30) || k == TABLE_N) acc = 64'd1 << 30;
            sine_q30[k] = acc;
        end
    endfunction

    function automatic void wave_sine(input longint unsigned idx,
                                      output longint unsigned mag, output bit neg);
        longint unsigned i;
        longint unsigned q;
        longint unsigned m;
        i   = idx % (4 * TABLE_N);
        q   = i / TABLE_N;
        m   = i % TABLE_N;
        mag = q[0] ? sine_q30[TABLE_N - m] : sine_q30[m];
        neg = (q >= 2) && (mag != 0);
    endfunction

    function automatic logic [24:0] scale_by_radius(input longint unsigned mag, input bit neg);
        longint unsigned v;
        v = (mag * geo_radius + (64'd1 << 29)) >> 30;
        if (v > 64'd16777215) v = 64'd16777215;
        return neg ? 25'(-v) : 25'(v);
    endfunction

    function automatic void sphere_point(input int unsigned r, input int unsigned c,
                                         input int unsigned segs, input int unsigned rows,
                                         output t_vertex v);
        longint unsigned w, y, sx, cz, xm, zm, idx;
        bit wn, yn, sxn, czn;
        if (r >= rows) begin
            w = 0; wn = 0; y = 64'd1 << 30; yn = 1;
        end else begin
            idx = (2 * TABLE_N * r + rows / 2) / rows;
            wave_sine(idx, w, wn);
            wave_sine(idx + TABLE_N, y, yn);
        end
        if (c >= segs) begin
            sx = 0; sxn = 0; cz = 64'd1 << 30; czn = 0;
        end else begin
            idx = (4 * TABLE_N * c + segs / 2) / segs;
            wave_sine(idx, sx, sxn);
            wave_sine(idx + TABLE_N, cz, czn);
        end
        xm  = (sx * w + (64'd1 << 29)) >> 30;
        zm  = (cz * w + (64'd1 << 29)) >> 30;
        v.x = scale_by_radius(xm, (sxn != wn) && xm != 0);
        v.y = scale_by_radius(y, yn);
        v.z = scale_by_radius(zm, (czn != wn) && zm != 0);
    endfunction

    // Walks the mesh one step and queues the six corners of the quad it lands on.
    function automatic void predict_quad(input bit restart);
        int unsigned segs;
        int unsigned rows;
        int unsigned nr;
        int unsigned nc;
        bit          at_end;
        t_vertex     v;
        bit [5:0]    row_back;
        bit [5:0]    col_back;
        row_back = 6'b00_1011;
        col_back = 6'b100_101;
        segs = (geo_cols == 0) ? 1 : geo_cols;
        rows = ((geo_rings > 254) ? 254 : geo_rings) + 1;
        if (restart) begin
            walk_row  = 1;
            walk_col  = 1;
            walk_done = 0;
        end else begin
            if (walk_done) return;
            nr = walk_row;
            nc = walk_col;
            if (nc >= segs) begin
                nc = 1;
                nr++;
            end else begin
                nc++;
            end
            if (nr > rows) begin
                walk_done = 1;
                return;
            end
            walk_row = nr;
            walk_col = nc;
        end
        at_end = (walk_row >= rows) && (walk_col >= segs);
        for (int k = 0; k < 6; k++) begin
            sphere_point(walk_row - row_back[k], walk_col - col_back[k], segs, rows, v);
            v.corner   = 3'(k);
            v.last     = (3'(k) == LAST_CORNER);
            v.mesh_end = at_end;
            vertex_q   = {vertex_q, v};
        end
        quad_count++;
        if (at_end) walk_done = 1;
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            vertex_count++;
            if (vertex_q.size() == 0) begin
                error_count++;
                $display("%0t: unexpected vertex transaction %h", $time, m_axis_tdata);
            end else begin
                exp_v = vertex_q.pop_front();
                if (m_axis_tdata[24:0] !== exp_v.x) begin
                    error_count++;
                    $display("%0t: x expected %h actual %h", $time, exp_v.x,
                             m_axis_tdata[24:0]);
                end
                if (m_axis_tdata[49:25] !== exp_v.y) begin
                    error_count++;
                    $display("%0t: y expected %h actual %h", $time, exp_v.y,
                             m_axis_tdata[49:25]);
                end
                if (m_axis_tdata[74:50] !== exp_v.z) begin
                    error_count++;
                    $display("%0t: z expected %h actual %h", $time, exp_v.z,
                             m_axis_tdata[74:50]);
                end
                if (m_axis_tdata[77:75] !== exp_v.corner) begin
                    error_count++;
                    $display("%0t: corner expected %0d actual %0d", $time, exp_v.corner,
                             m_axis_tdata[77:75]);
                end
                if (m_axis_tlast !== exp_v.last) begin
                    error_count++;
                    $display("%0t: last expected %b actual %b", $time, exp_v.last,
                             m_axis_tlast);
                end
                if (m_axis_tuser !== exp_v.mesh_end) begin
                    error_count++;
                    $display("%0t: mesh_end expected %b actual %b", $time,
                             exp_v.mesh_end, m_axis_tuser);
                end
            end
        end
    end

    // Output ready driver; a pending hold-off keeps the receiver stalled.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off      <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_step(input bit restart);
        s_axis_tdata  <= IN_TDATA_W'(restart);
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_quad(restart);
        item_count++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    // Waits for every queued vertex, then for the block to finish any step
    // that produces nothing.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (vertex_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int unsigned value);
        i_cfg_index <= idx;
        i_cfg_data  <= RADIUS_W'(value);
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RADIUS:  geo_radius = value & 24'hFFFFFF;
            CFG_COLUMNS: geo_cols   = value & 8'hFF;
            CFG_RINGS:   geo_rings  = value & 8'hFF;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input int unsigned radius, input int unsigned cols,
                                input int unsigned rings);
        write_reg(CFG_RADIUS, radius);
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_RINGS, rings);
    endtask

    task automatic test_reset_geometry();
        send_step(0);
        send_step(1);
        repeat (3) send_step(0);
        wait_idle();
    endtask

    task automatic test_extremes();
        set_geometry(24'hFFFFFF, 255, 254);
        send_step(1);
        send_step(0);
        wait_idle();
        set_geometry(1, 1, 0);
        send_step(1);
        send_step(0);
        wait_idle();
        set_geometry(0, 0, 255);
        send_step(1);
        send_step(0);
        wait_idle();
        set_geometry(24'h800000, 3, 1);
        send_step(1);
        repeat (6) send_step(0);
        wait_idle();
    endtask

    // Geometry changed while a mesh is being walked.
    task automatic test_midmesh_change();
        set_geometry(24'h012345, 4, 3);
        send_step(1);
        repeat (5) send_step(0);
        wait_idle();
        write_reg(CFG_COLUMNS, 2);
        send_step(0);
        wait_idle();
        write_reg(CFG_RINGS, 0);
        send_step(0);
        send_step(0);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_geometry(24'h00C000, 3, 2);
        hold_off <= 600;
        send_step(1);
        repeat (4) send_step(0);
        wait_idle();
    endtask

    task automatic test_random_walk(input int idle_pct, input int stall_pct, input int steps);
        int sent;
        int quads;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        set_geometry($urandom_range(24'hFFFFFF), $urandom_range(5, 1), $urandom_range(3));
        sent = 0;
        while (sent < steps) begin
            quads = ((geo_cols == 0) ? 1 : geo_cols) * (geo_rings + 1);
            send_step(1);
            sent++;
            for (int k = 0; k < quads + 1 && sent < steps; k++) begin
                // Occasional early restart breaks the sequence.
                send_step($urandom_range(99) < 8);
                sent++;
            end
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_RADIUS;
        i_cfg_data     = '0;
        cycle_count    = 0;
        error_count    = 0;
        vertex_count   = 0;
        quad_count     = 0;
        item_count     = 0;
        hold_off       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        geo_radius     = 32768;
        geo_cols       = 32;
        geo_rings      = 16;
        walk_row       = 1;
        walk_col       = 1;
        walk_done      = 1;
        build_sine_q30();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_extremes();
        test_midmesh_change();
        test_backpressure();
        test_random_walk(0, 0, 20);
        test_random_walk(48, 0, 20);
        test_random_walk(0, 48, 20);
        test_random_walk(34, 34, 20);

        $display("Sent %0d input items covering %0d quads; checked %0d vertices.",
                 item_count, quad_count, vertex_count);
        $display("Geometries included extreme radius, column and ring counts.");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end
endmodule
